// ===== design/ptsc_pkg.sv =====
// Package for the point-to-screen projection unit.
// Holds field widths, register indexes, control bundles and the saturation function.
// No dependencies.
package ptsc_pkg;

  localparam int NUM_W = 50;
  localparam int MAG_W = 49;
  localparam int QB    = 41;
  localparam int REM_W = 64;
  localparam int CMP_W = MAG_W + QB;
  localparam int QC_W  = 34;
  localparam int V_W   = 36;
  localparam int P_W   = 54;
  localparam int LANES = 3;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_ORIGIN = 3'd4,
    REG_SIZE   = 3'd5
  } reg_idx_t;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    logic valid;
    logic last;
  } xf_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             wz;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] hi;
    logic signed [P_W-1:0] lo;
    hi = P_W'(32'sh7fffffff);
    lo = -P_W'(33'sh080000000);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== design/ptsc_point_if.sv =====
// Input channel of the projection unit: one 3D point word per handshake.
// Depends on nothing.
interface ptsc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               last_in;

  modport source (output valid, point_x, point_y, point_z, last_in, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_in, output ready);
endinterface

// ===== design/ptsc_screen_if.sv =====
// Output channel of the projection unit: one screen position word per handshake.
// Depends on nothing.
interface ptsc_screen_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;
  logic               point_ok;
  logic               last_out;

  modport source (output valid, screen_x, screen_y, depth, point_ok, last_out, input ready);
  modport sink (input valid, screen_x, screen_y, depth, point_ok, last_out, output ready);
endinterface

// ===== design/project_point_to_screen_unit.sv =====
// Projects one 3D point per clock to screen space: 4x4 matrix transform, perspective divide
// by w, viewport scale and offset, saturation to signed Q15.16. The pipeline runs the
// matrix products and sums, then the divider (one quotient bit a stage), then the viewport
// map. A new point is taken every cycle; when the output word is not taken, every stage
// holds. A zero w gives zero outputs with point_ok low. The user must write registers
// through cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
module project_point_to_screen_unit #(
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  ptsc_point_if.sink    points,
  ptsc_screen_if.source screens
);

  localparam logic [63:0] ONE = 64'(1) << COEF_FRAC_BITS;

  logic [3:0][63:0] rows;
  logic [31:0]      origin;
  logic [31:0]      size;
  logic             adv;

  ptsc_pkg::num_t            n [4];
  ptsc_pkg::num_t            nd [3];
  ptsc_pkg::xf_ctl_t         xctl;
  logic [ptsc_pkg::QB-1:0]   q [3];
  ptsc_pkg::div_ctl_t        dctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ONE;
      rows[1] <= ONE << 16;
      rows[2] <= ONE << 32;
      rows[3] <= ONE << 48;
      origin  <= '0;
      size    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptsc_pkg::REG_ROW0:   rows[0] <= cfg_data;
        ptsc_pkg::REG_ROW1:   rows[1] <= cfg_data;
        ptsc_pkg::REG_ROW2:   rows[2] <= cfg_data;
        ptsc_pkg::REG_ROW3:   rows[3] <= cfg_data;
        ptsc_pkg::REG_ORIGIN: origin  <= cfg_data[31:0];
        ptsc_pkg::REG_SIZE:   size    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign adv           = !screens.valid || screens.ready;
  assign points.ready  = adv;

  ptsc_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (points.valid),
    .x        (points.point_x),
    .y        (points.point_y),
    .z        (points.point_z),
    .last     (points.last_in),
    .rows     (rows),
    .n        (n),
    .ctl      (xctl)
  );

  assign nd[0] = n[0];
  assign nd[1] = n[1];
  assign nd[2] = n[2];

  ptsc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .n      (nd),
    .w      (n[3]),
    .ctl_in (xctl),
    .q      (q),
    .ctl    (dctl)
  );

  ptsc_view u_view (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .q        (q),
    .ctl_in   (dctl),
    .origin   (origin),
    .size     (size),
    .valid    (screens.valid),
    .screen_x (screens.screen_x),
    .screen_y (screens.screen_y),
    .depth    (screens.depth),
    .point_ok (screens.point_ok),
    .last_out (screens.last_out)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    screens.valid && !screens.point_ok |->
      screens.screen_x == 0 && screens.screen_y == 0 && screens.depth == 0)
    else $error("failed projection word carries nonzero position");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    points.ready == (!screens.valid || screens.ready))
    else $error("input ready does not follow pipeline advance");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !screens.valid)
    else $error("output word valid right after reset");

endmodule

// ===== design/ptsc_xform.sv =====
// Matrix transform: two stages, products then row sums of (x, y, z, 1).
// Depends on ptsc_pkg.
module ptsc_xform (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [31:0]       x,
  input  logic signed [31:0]       y,
  input  logic signed [31:0]       z,
  input  logic                     last,
  input  logic [3:0][63:0]         rows,
  output ptsc_pkg::num_t           n [4],
  output ptsc_pkg::xf_ctl_t        ctl
);

  logic signed [47:0] prod [4][3];
  logic [15:0]        coef3 [4];
  ptsc_pkg::xf_ctl_t  ctl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl  <= '0;
    end else if (en) begin
      ctl1 <= '{valid: in_valid, last: last};
      ctl  <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= $signed(rows[r][15:0]) * x;
        prod[r][1] <= $signed(rows[r][31:16]) * y;
        prod[r][2] <= $signed(rows[r][47:32]) * z;
        coef3[r]   <= rows[r][63:48];
      end
      for (int r = 0; r < 4; r++) begin
        n[r] <= ptsc_pkg::NUM_W'(prod[r][0]) + ptsc_pkg::NUM_W'(prod[r][1])
              + ptsc_pkg::NUM_W'(prod[r][2])
              + $signed({{18{coef3[r][15]}}, coef3[r], 16'b0});
      end
    end
  end

endmodule

// ===== design/ptsc_div.sv =====
// Pipelined restoring divider, three lanes sharing the w divisor, one quotient bit a stage.
// Depends on ptsc_pkg.
module ptsc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  ptsc_pkg::num_t                  n [3],
  input  ptsc_pkg::num_t                  w,
  input  ptsc_pkg::xf_ctl_t               ctl_in,
  output logic [ptsc_pkg::QB-1:0]         q [3],
  output ptsc_pkg::div_ctl_t              ctl
);

  localparam int QB = ptsc_pkg::QB;
  localparam int L  = ptsc_pkg::LANES;

  logic [ptsc_pkg::NUM_W-1:0] amag [L];
  logic [ptsc_pkg::NUM_W-1:0] wmag;

  logic [ptsc_pkg::REM_W-1:0] e_nm [L];
  logic [ptsc_pkg::MAG_W-1:0] e_dm;
  ptsc_pkg::div_ctl_t         e_ctl;
  ptsc_pkg::div_ctl_t         sc0_next;

  logic [ptsc_pkg::REM_W-1:0] rem [QB+1][L];
  logic [QB-1:0]              qs  [QB+1][L];
  logic [ptsc_pkg::MAG_W-1:0] dm  [QB+1];
  ptsc_pkg::div_ctl_t         sc  [QB+1];

  logic [ptsc_pkg::REM_W-1:0] rem_next [QB+1][L];
  logic                       ge [QB+1][L];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      amag[l] = n[l][ptsc_pkg::NUM_W-1] ? -n[l] : n[l];
    end
    wmag = w[ptsc_pkg::NUM_W-1] ? -w : w;
  end

  always_comb begin
    sc0_next = e_ctl;
    for (int l = 0; l < L; l++) begin
      sc0_next.ovf[l] = {{(ptsc_pkg::CMP_W-ptsc_pkg::REM_W){1'b0}}, e_nm[l]}
                        >= {e_dm, {QB{1'b0}}};
    end
  end

  always_comb begin
    logic [ptsc_pkg::CMP_W-1:0] dsh;
    for (int i = 0; i <= QB; i++) begin
      for (int l = 0; l < L; l++) begin
        ge[i][l]       = 1'b0;
        rem_next[i][l] = rem[i][l];
      end
    end
    for (int i = 1; i <= QB; i++) begin
      dsh = {{QB{1'b0}}, dm[i-1]} << (QB - i);
      for (int l = 0; l < L; l++) begin
        ge[i][l] = {{(ptsc_pkg::CMP_W-ptsc_pkg::REM_W){1'b0}}, rem[i-1][l]} >= dsh;
        rem_next[i][l] = ge[i][l] ? rem[i-1][l] - dsh[ptsc_pkg::REM_W-1:0] : rem[i-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ctl <= '0;
      for (int i = 0; i <= QB; i++) sc[i] <= '0;
    end else if (en) begin
      e_ctl.valid <= ctl_in.valid;
      e_ctl.last  <= ctl_in.last;
      e_ctl.wz    <= (w == '0);
      for (int l = 0; l < L; l++) begin
        e_ctl.neg[l] <= n[l][ptsc_pkg::NUM_W-1] ^ w[ptsc_pkg::NUM_W-1];
      end
      e_ctl.ovf <= '0;
      sc[0] <= sc0_next;
      for (int i = 1; i <= QB; i++) sc[i] <= sc[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        e_nm[l] <= {1'b0, amag[l][ptsc_pkg::MAG_W-2:0], 15'b0};
      end
      e_dm <= wmag[ptsc_pkg::MAG_W-1:0];
      dm[0] <= e_dm;
      for (int l = 0; l < L; l++) begin
        rem[0][l] <= e_nm[l];
        qs[0][l]  <= '0;
      end
      for (int i = 1; i <= QB; i++) begin
        dm[i] <= dm[i-1];
        for (int l = 0; l < L; l++) begin
          rem[i][l] <= rem_next[i][l];
          qs[i][l]  <= qs[i-1][l] | (QB'(ge[i][l]) << (QB - i));
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) q[l] = qs[QB][l];
    ctl = sc[QB];
  end

endmodule

// ===== design/ptsc_view.sv =====
// Viewport map: clamp and sign the quotient, scale x and y by the viewport, add origin, saturate.
// Three stages, the last one is the output register. Depends on ptsc_pkg.
module ptsc_view (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [ptsc_pkg::QB-1:0]    q [3],
  input  ptsc_pkg::div_ctl_t         ctl_in,
  input  logic [31:0]                origin,
  input  logic [31:0]                size,
  output logic                       valid,
  output logic signed [31:0]         screen_x,
  output logic signed [31:0]         screen_y,
  output logic signed [31:0]         depth,
  output logic                       point_ok,
  output logic                       last_out
);

  localparam logic [ptsc_pkg::QB-1:0] QCAP = ptsc_pkg::QB'(1) << (ptsc_pkg::QC_W - 1);

  logic signed [ptsc_pkg::V_W-1:0]     v [3];
  logic signed [ptsc_pkg::V_W-1:0]     v_next [3];
  logic signed [ptsc_pkg::P_W-1:0]     px;
  logic signed [ptsc_pkg::P_W-1:0]     py;
  logic signed [ptsc_pkg::V_W-1:0]     vz;
  ptsc_pkg::div_ctl_t                  c1;
  ptsc_pkg::div_ctl_t                  c2;

  always_comb begin
    logic [ptsc_pkg::QC_W-1:0]          qc;
    logic signed [ptsc_pkg::V_W-1:0]    s;
    for (int l = 0; l < 3; l++) begin
      qc = (ctl_in.ovf[l] || q[l] > QCAP) ? QCAP[ptsc_pkg::QC_W-1:0]
                                          : q[l][ptsc_pkg::QC_W-1:0];
      s  = $signed({2'b0, qc});
      v_next[l] = (ctl_in.neg[l] ? -s : s) + ptsc_pkg::V_W'(32'sd32768);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1    <= '0;
      c2    <= '0;
      valid <= 1'b0;
    end else if (en) begin
      c1    <= ctl_in;
      c2    <= c1;
      valid <= c2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v  <= v_next;
      px <= ptsc_pkg::P_W'(v[0]) * $signed({1'b0, size[15:0]});
      py <= ptsc_pkg::P_W'(v[1]) * $signed({1'b0, size[31:16]});
      vz <= v[2];
      last_out <= c2.last;
      point_ok <= !c2.wz;
      if (c2.wz) begin
        screen_x <= '0;
        screen_y <= '0;
        depth    <= '0;
      end else begin
        screen_x <= ptsc_pkg::sat32(px + $signed({22'b0, origin[15:0], 16'b0}));
        screen_y <= ptsc_pkg::sat32(py + $signed({22'b0, origin[31:16], 16'b0}));
        depth    <= ptsc_pkg::sat32(ptsc_pkg::P_W'(vz));
      end
    end
  end

endmodule

// ===== tb/project_point_to_screen_unit_tb.sv =====
// Self-checking bench for project_point_to_screen_unit: streams 3D points through the
// matrix, divide and viewport stages and checks every screen word against a local predictor.
// Depends on ptsc_pkg, ptsc_point_if, ptsc_screen_if and project_point_to_screen_unit.

typedef struct {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic               last;
} point_t;

typedef struct {
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [31:0] dep;
  logic               ok;
  logic               last;
} screen_word_t;

class screen_scoreboard;
  logic [63:0]  rows[4];
  logic [31:0]  origin;
  logic [31:0]  size;
  screen_word_t due[$];
  int           mismatches;
  int           checked;

  function new();
    rows[0] = 64'd1 << 10;
    rows[1] = 64'd1 << 26;
    rows[2] = 64'd1 << 42;
    rows[3] = 64'd1 << 58;
    origin = '0;
    size = '0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] data);
    if (idx <= ptsc_pkg::REG_ROW3) rows[idx] = data;
    else if (idx == ptsc_pkg::REG_ORIGIN) origin = data[31:0];
    else if (idx == ptsc_pkg::REG_SIZE) size = data[31:0];
  endfunction

  function longint row_sum(logic [63:0] row, longint x, longint y, longint z);
    return longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y +
           longint'($signed(row[47:32])) * z + longint'($signed(row[63:48])) * 65536;
  endfunction

  function longint half_map(longint n, longint d);
    logic [127:0] mn;
    logic [127:0] md;
    logic [127:0] q;
    longint       s;
    mn = n < 0 ? 128'(-n) : 128'(n);
    md = d < 0 ? 128'(-d) : 128'(d);
    q = (mn << 15) / md;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    s = longint'(q[63:0]);
    if ((n < 0) != (d < 0)) s = -s;
    return s + 32768;
  endfunction

  function logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function void note_point(point_t p);
    screen_word_t e;
    longint       w;
    w = row_sum(rows[3], p.x, p.y, p.z);
    e.last = p.last;
    if (w == 0) begin
      e.sx = 0;
      e.sy = 0;
      e.dep = 0;
      e.ok = 0;
    end else begin
      e.sx = clamp32(half_map(row_sum(rows[0], p.x, p.y, p.z), w) * longint'(size[15:0]) +
                     longint'(origin[15:0]) * 65536);
      e.sy = clamp32(half_map(row_sum(rows[1], p.x, p.y, p.z), w) * longint'(size[31:16]) +
                     longint'(origin[31:16]) * 65536);
      e.dep = clamp32(half_map(row_sum(rows[2], p.x, p.y, p.z), w));
      e.ok = 1;
    end
    due.push_back(e);
  endfunction

  function void check_word(screen_word_t a);
    screen_word_t e;
    checked++;
    if (due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected screen word x=%0d y=%0d", a.sx, a.sy);
      return;
    end
    e = due.pop_front();
    if (a.sx !== e.sx || a.sy !== e.sy || a.dep !== e.dep || a.ok !== e.ok ||
        a.last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch word %0d: exp x=%0d y=%0d d=%0d ok=%b l=%b got x=%0d y=%0d d=%0d ok=%b l=%b",
                 checked, e.sx, e.sy, e.dep, e.ok, e.last, a.sx, a.sy, a.dep, a.ok, a.last);
    end
  endfunction

  function int pending();
    return due.size();
  endfunction
endclass

module project_point_to_screen_unit_tb;
  localparam logic [2:0] UNUSED_INDEX = 3'd7;
  localparam int FLUSH_CYCLES = 60;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_len = 0;
  int          hold_left = 0;
  int          sent = 0;
  screen_scoreboard sb = new();

  ptsc_point_if  points();
  ptsc_screen_if screens();

  project_point_to_screen_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .points(points), .screens(screens)
  );

  always #5 clk = ~clk;

  initial begin
    points.valid = 0;
    points.point_x = 0;
    points.point_y = 0;
    points.point_z = 0;
    points.last_in = 0;
    screens.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst && screens.valid && screens.ready)
      sb.check_word('{screens.screen_x, screens.screen_y, screens.depth,
                      screens.point_ok, screens.last_out});
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (rst) begin
      screens.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      screens.ready <= 0;
    end else begin
      screens.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      points.valid <= 0;
      @(posedge clk);
    end
    points.valid <= 1;
    points.point_x <= p.x;
    points.point_y <= p.y;
    points.point_z <= p.z;
    points.last_in <= p.last;
    do @(posedge clk); while (!points.ready);
    sb.note_point(p);
    sent++;
  endtask

  task automatic drain();
    points.valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    if ($urandom_range(9) < 7) return 16'($urandom_range(4096) - 2048);
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0, 1: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
      2: return 32'($signed($urandom_range(1 << 27)) - (1 << 26));
      default: return $urandom();
    endcase
  endfunction

  task automatic load_matrix(logic [63:0] r0, r1, r2, r3);
    write_reg(ptsc_pkg::REG_ROW0, r0);
    write_reg(ptsc_pkg::REG_ROW1, r1);
    write_reg(ptsc_pkg::REG_ROW2, r2);
    write_reg(ptsc_pkg::REG_ROW3, r3);
  endtask

  task automatic send_random(int n);
    point_t p;
    repeat (n) begin
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      p.last = $urandom_range(3) == 0;
      send_point(p);
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  initial begin
    point_t      p;
    logic [31:0] hard[6];
    logic [63:0] persp3;
    int          i;
    int          j;
    int          k;
    hard = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00010000};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_random(100);
    drain();

    // perspective: w = -z, so z = 0 gives a zero w and tiny z a huge quotient
    persp3 = {16'h0000, 16'hfc00, 16'h0000, 16'h0000};
    load_matrix({16'h0000, 16'h0000, 16'h0000, 16'h0800},
                {16'h0000, 16'h0000, 16'h0800, 16'h0000},
                {16'h0400, 16'h0c00, 16'h0000, 16'h0000}, persp3);
    write_reg(ptsc_pkg::REG_ORIGIN, {16'd240, 16'd320});
    write_reg(ptsc_pkg::REG_SIZE, {16'd480, 16'd640});
    write_reg(UNUSED_INDEX, 64'hffff_ffff_ffff_ffff);
    for (i = 0; i < 24; i++) begin
      p.x = hard[i % 6];
      p.y = hard[(i / 6 + i) % 6];
      p.z = (i < 4) ? 32'h0 : hard[(i * 5 + 1) % 6];
      p.last = i[0];
      send_point(p);
    end
    drain();

    for (k = 0; k < 6; k++) begin
      set_idling(k);
      case (k)
        0: begin
          load_matrix({16'h0400, 16'h0, 16'h0, 16'h0}, {16'h0, 16'h0400, 16'h0, 16'h0},
                      {16'h0, 16'h0, 16'h0400, 16'h0}, persp3);
          write_reg(ptsc_pkg::REG_ORIGIN, 32'h0);
          write_reg(ptsc_pkg::REG_SIZE, 32'h0);
        end
        1: begin
          load_matrix({4{16'h7fff}}, {4{16'h8000}}, {2{16'h7fff, 16'h8000}}, {4{16'h8000}});
          write_reg(ptsc_pkg::REG_ORIGIN, 32'hffffffff);
          write_reg(ptsc_pkg::REG_SIZE, 32'hffffffff);
        end
        2: begin
          load_matrix(64'h0, 64'h0, 64'h0, 64'h0);
          write_reg(ptsc_pkg::REG_SIZE, 32'h00ff00ff);
        end
        default: begin
          for (j = 0; j < 4; j++)
            write_reg(3'(j), {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
          write_reg(ptsc_pkg::REG_ORIGIN, $urandom());
          write_reg(ptsc_pkg::REG_SIZE, (k == 5) ? $urandom() :
                                        {16'($urandom_range(2048)),
                                         16'($urandom_range(2048))});
        end
      endcase
      if (k == 3) hold_len = 300;
      send_random(70);
      if (k == 4) drain();
      send_random(70);
      drain();
    end

    set_idling(3);
    for (k = 0; k < 2; k++) begin
      for (j = 0; j < 4; j++)
        write_reg(3'(j), {16'($urandom_range(8192) - 4096), rand_coef(), rand_coef(),
                          rand_coef()});
      write_reg(ptsc_pkg::REG_ORIGIN, {16'($urandom_range(1080)), 16'($urandom_range(1920))});
      write_reg(ptsc_pkg::REG_SIZE, {16'($urandom_range(1080)), 16'($urandom_range(1920))});
      send_random(20);
      drain();
    end

    $display("points sent: %0d, screen words checked: %0d, over ten register settings",
             sent, sb.checked);
    $display("covered zero w, saturation, reset identity and stall/idle mixes");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches: %0d", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d words outstanding", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
